// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ccb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types, character codes and lexer mode codes for the comment blanker.
// ----------------------------------------------------------------------------
package ccb_pkg;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Lexer modes; the unused codes behave as normal code.
   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_SQ     = 3'd1;
   localparam logic [2:0] MODE_DQ     = 3'd2;
   localparam logic [2:0] MODE_LINE   = 3'd3;
   localparam logic [2:0] MODE_BLOCK  = 3'd4;

   // Output queue depth and pointer width.
   localparam int unsigned QUEUE_DEPTH = 3;
   localparam int unsigned PTR_W       = 2;

   // Lexer state carried from byte to byte.
   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] quote_count;
      logic       first_bs;
      logic       bs_odd;
   } ccb_lex_state_type;

   // One output word.
   typedef struct packed {
      logic       last;
      logic       blanked;
      logic [7:0] data;
   } ccb_word_type;

   // Up to two words pushed into the output queue in one cycle.
   typedef struct packed {
      logic         v0;
      ccb_word_type w0;
      logic         v1;
      ccb_word_type w1;
   } ccb_push_type;

   // Occupancy reported by the output queue.
   typedef struct packed {
      logic [PTR_W-1:0] count;
   } ccb_queue_stat_type;

   // Advance a queue pointer, wrapping at the queue depth.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/ccb_lex.sv =====
// ----------------------------------------------------------------------------
// ccb_lex
// Classifies one byte against the current lexer state and an optional
// lookahead byte, and gives the output word and the next lexer state.
// ----------------------------------------------------------------------------
module ccb_lex
   import ccb_pkg::*;
(
   input  ccb_lex_state_type state_cur,
   input  logic [7:0]        cur_byte,
   input  logic              has_next,
   input  logic [7:0]        next_byte,
   input  logic              consumed,
   input  logic              is_last,
   output ccb_lex_state_type state_nxt,
   output ccb_word_type      word,
   output logic              take
);

   logic blank;
   logic next_is_nl;
   logic next_is_slash;
   logic next_is_star;

   // Lookahead compares are void when no next byte exists.
   assign next_is_nl    = has_next && (next_byte == CH_NL);
   assign next_is_slash = has_next && (next_byte == CH_SLASH);
   assign next_is_star  = has_next && (next_byte == CH_STAR);

   // Mode transitions and blanking decision.
   always_comb begin
      state_nxt = state_cur;
      blank     = 1'b0;
      take      = 1'b0;
      if (consumed) begin
         // Second byte of a comment opener or closer.
         blank = 1'b1;
      end else begin
         case (state_cur.mode)
            MODE_SQ: begin
               if (cur_byte == CH_SQUOTE &&
                   !(state_cur.quote_count == 2'd1 && state_cur.first_bs)) begin
                  state_nxt.mode = MODE_NORMAL;
               end
               if (state_cur.quote_count == 2'd0) begin
                  state_nxt.first_bs = (cur_byte == CH_BSLASH);
               end
               if (state_cur.quote_count != 2'd3) begin
                  state_nxt.quote_count = state_cur.quote_count + 2'd1;
               end
            end
            MODE_DQ: begin
               if (cur_byte == CH_DQUOTE && !state_cur.bs_odd) begin
                  state_nxt.mode = MODE_NORMAL;
               end
               state_nxt.bs_odd = (cur_byte == CH_BSLASH) ? !state_cur.bs_odd : 1'b0;
            end
            MODE_LINE: begin
               if (cur_byte == CH_NL) begin
                  state_nxt.mode = MODE_NORMAL;
               end else if (!(cur_byte == CH_CR && next_is_nl)) begin
                  blank = 1'b1;
               end
            end
            MODE_BLOCK: begin
               blank = 1'b1;
               if (cur_byte == CH_STAR && next_is_slash) begin
                  state_nxt.mode = MODE_NORMAL;
                  take           = 1'b1;
               end
            end
            default: begin
               state_nxt.mode = MODE_NORMAL;
               if (cur_byte == CH_SQUOTE) begin
                  state_nxt.mode        = MODE_SQ;
                  state_nxt.quote_count = 2'd0;
                  state_nxt.first_bs    = 1'b0;
               end else if (cur_byte == CH_DQUOTE) begin
                  state_nxt.mode   = MODE_DQ;
                  state_nxt.bs_odd = 1'b0;
               end else if (cur_byte == CH_SLASH && (next_is_slash || next_is_star)) begin
                  state_nxt.mode = next_is_slash ? MODE_LINE : MODE_BLOCK;
                  blank          = 1'b1;
                  take           = 1'b1;
               end
            end
         endcase
      end
   end

   // Output word.
   assign word.data    = blank ? CH_SPACE : cur_byte;
   assign word.blanked = blank;
   assign word.last    = is_last;

endmodule

// ===== rtl/ccb_out_queue.sv =====
// ----------------------------------------------------------------------------
// ccb_out_queue
// Three-word output queue that takes up to two words a cycle and releases
// one word a cycle on the result stream while pop is high.
// ----------------------------------------------------------------------------
module ccb_out_queue
   import ccb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ccb_push_type       push,
   input  logic               pop,
   output logic               out_valid,
   output ccb_word_type       out_word,
   output ccb_queue_stat_type stat
);

   ccb_word_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W-1:0] count_ff;
   logic [PTR_W-1:0] count_in;
   logic [PTR_W-1:0] wr_ptr_2nd;
   logic [PTR_W-1:0] n_push;
   logic             do_pop;
   ccb_word_type     first_word;

   assign out_valid  = (count_ff != '0);
   assign out_word   = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign do_pop     = pop && out_valid;

   // Pointer and count bookkeeping.
   always_comb begin
      n_push     = PTR_W'(push.v0) + PTR_W'(push.v1);
      wr_ptr_2nd = ptr_inc(wr_ptr_ff);
      first_word = push.v0 ? push.w0 : push.w1;
      wr_ptr_in  = wr_ptr_ff;
      if (n_push == PTR_W'(2)) begin
         wr_ptr_in = ptr_inc(wr_ptr_2nd);
      end else if (n_push == PTR_W'(1)) begin
         wr_ptr_in = wr_ptr_2nd;
      end
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + n_push - PTR_W'(do_pop);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; the second word lands one place after the first.
   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         entry_ff[wr_ptr_ff] <= first_word;
      end
      if (n_push == PTR_W'(2)) begin
         entry_ff[wr_ptr_2nd] <= push.w1;
      end
   end

endmodule

// ===== rtl/c_comment_blanker_top.sv =====
// ----------------------------------------------------------------------------
// c_comment_blanker_top
// Streaming C comment blanker: comment bytes become spaces, length is kept.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while its queue has room and
// returns each byte one accepted byte later, since a byte is classified
// only once its successor is known. Line and block comments, with their
// opening and closing tokens, come out as spaces with the tuser flag set;
// literals in quotes are left alone, as is a carriage return that directly
// precedes the newline ending a line comment. The word with tlast releases
// the held byte, if any, and itself, so it can make two output words; the
// three-word output queue accepts a new byte while it holds at most one
// word, which sustains one byte per cycle while results are taken.
// After the last byte the lexer is back in normal code for the next text.
module c_comment_blanker_top
   import ccb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // was_blanked
   output logic       rsp_tlast    // out_last
);

`include "assert_macros.svh"

   ccb_lex_state_type  lex_ff;
   ccb_lex_state_type  lex_in;
   logic [7:0]         held_byte_ff;
   logic [7:0]         held_byte_in;
   logic               held_valid_ff;
   logic               held_valid_in;
   logic               held_consumed_ff;
   logic               held_consumed_in;
   ccb_lex_state_type  lex0_nxt;
   ccb_lex_state_type  lex_mid;
   ccb_lex_state_type  lex1_nxt;
   ccb_word_type       word0;
   ccb_word_type       word1;
   ccb_word_type       q_word;
   logic               take0;
   logic               take_held;
   logic               take_last;
   logic               accept;
   ccb_push_type       push;
   ccb_queue_stat_type q_stat;

   assign req_tready = (q_stat.count <= PTR_W'(1));
   assign accept     = req_tvalid && req_tready;

   // Held byte, looked at with the incoming byte as lookahead.
   ccb_lex u_lex_held (
      .state_cur (lex_ff),
      .cur_byte  (held_byte_ff),
      .has_next  (1'b1),
      .next_byte (req_tdata),
      .consumed  (held_consumed_ff),
      .is_last   (1'b0),
      .state_nxt (lex0_nxt),
      .word      (word0),
      .take      (take0)
   );

   assign take_held = held_valid_ff && take0;
   assign lex_mid   = held_valid_ff ? lex0_nxt : lex_ff;

   // Incoming byte as the final byte of a text, with no lookahead.
   ccb_lex u_lex_last (
      .state_cur (lex_mid),
      .cur_byte  (req_tdata),
      .has_next  (1'b0),
      .next_byte (8'h00),
      .consumed  (take_held),
      .is_last   (1'b1),
      .state_nxt (lex1_nxt),
      .word      (word1),
      .take      (take_last)
   );

   // Words pushed on an accepted byte.
   always_comb begin
      push.v0 = accept && held_valid_ff;
      push.w0 = word0;
      push.v1 = accept && req_tlast;
      push.w1 = word1;
   end

   // Next lexer and lookahead state.
   always_comb begin
      lex_in           = lex_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      held_consumed_in = held_consumed_ff;
      if (accept) begin
         if (req_tlast) begin
            lex_in           = '0;
            held_byte_in     = '0;
            held_valid_in    = 1'b0;
            held_consumed_in = 1'b0;
         end else begin
            lex_in           = lex_mid;
            held_byte_in     = req_tdata;
            held_valid_in    = 1'b1;
            held_consumed_in = take_held;
         end
      end
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff           <= '0;
         held_valid_ff    <= 1'b0;
         held_consumed_ff <= 1'b0;
      end else begin
         lex_ff           <= lex_in;
         held_valid_ff    <= held_valid_in;
         held_consumed_ff <= held_consumed_in;
      end
   end

   // Held byte payload.
   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   ccb_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_word  (q_word),
      .stat      (q_stat)
   );

   assign rsp_tdata = q_word.data;
   assign rsp_tuser = q_word.blanked;
   assign rsp_tlast = q_word.last;

   // A final byte leaves nothing held for the next text.
   `ASSERT_NEXT(a_last_clears_hold, accept && req_tlast, !held_valid_ff && lex_ff.mode == MODE_NORMAL, "hold not cleared after final byte")

   // Any other accepted byte is held as lookahead.
   `ASSERT_NEXT(a_byte_held, accept && !req_tlast, held_valid_ff && held_byte_ff == $past(req_tdata), "accepted byte not held")

   // A blanked word always carries a space.
   `ASSERT_SAME(a_blank_is_space, rsp_tvalid && rsp_tuser, rsp_tdata == CH_SPACE, "blanked word is not a space")

   // Without lookahead the final byte never pairs up with a following byte.
   `ASSERT_SAME(a_last_takes_nothing, 1'b1, !take_last, "final byte took a token byte")

   // Without lookahead the final byte cannot open a comment.
   `ASSERT_SAME(a_last_opens_nothing, lex1_nxt.mode == MODE_LINE || lex1_nxt.mode == MODE_BLOCK, lex1_nxt.mode == lex_mid.mode, "final byte opened a comment")

endmodule
